/* hw/rtl/stb_pkg.sv */
// Package for the software timer bank: sizes, command codes and the
// controller/datapath command and status types. No dependencies.
package stb_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int TIDX_W     = 4;   // fixed by the timer_index field
  localparam int CNT_W      = 5;   // holds 0..NUM_TIMERS

  localparam logic [2:0] KIND_TICK   = 3'd0;
  localparam logic [2:0] KIND_SETUP  = 3'd1;
  localparam logic [2:0] KIND_START  = 3'd2;
  localparam logic [2:0] KIND_STOP   = 3'd3;
  localparam logic [2:0] KIND_CHANGE = 3'd4;
  localparam logic [2:0] KIND_QUERY  = 3'd5;

  typedef enum logic [2:0] {
    OP_NOP, OP_LOAD, OP_TICK, OP_DUE, OP_SCAN, OP_FIRE, OP_EMIT, OP_EXEC
  } dp_op_e;

  typedef struct packed {
    dp_op_e            op;
    logic              resp;   // load a command result
    logic [TIDX_W-1:0] ent;    // scan entry
  } dp_cmd_t;

  typedef struct packed {
    logic due_none;            // no due timers left to report
  } dp_stat_t;

  // Ticks left: positive signed difference of a running timer, else zero.
  function automatic logic [30:0] ticks_left(logic run, logic [31:0] exp_t,
                                             logic [31:0] now);
    logic [31:0] d;
    d = exp_t - now;
    if (!run || d == 32'd0 || d[31]) return 31'd0;
    return d[30:0];
  endfunction

endpackage

/* hw/rtl/stb_ctrl.sv */
// Controller of the software timer bank: sequences commands and tick scans.
// Depends on stb_pkg.
module stb_ctrl import stb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  logic [2:0] kind_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o,
  output logic     busy_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_TINC, S_DUE, S_SCAN, S_FIRE, S_EMIT, S_EXEC, S_RESP
  } state_e;

  state_e            state_q;
  logic [TIDX_W-1:0] ent_q;
  logic              last_ent;

  assign last_ent = (ent_q == TIDX_W'(NUM_TIMERS - 1));
  assign busy_o   = (state_q != S_IDLE);

  // Command decode
  always_comb begin
    cmd_o.op   = OP_NOP;
    cmd_o.resp = 1'b0;
    cmd_o.ent  = ent_q;
    case (state_q)
      S_IDLE: if (start_i) cmd_o.op = OP_LOAD;
      S_TINC: cmd_o.op = OP_TICK;
      S_DUE:  cmd_o.op = OP_DUE;
      S_SCAN: cmd_o.op = OP_SCAN;
      S_FIRE: cmd_o.op = OP_FIRE;
      S_EMIT: cmd_o.op = OP_EMIT;
      S_EXEC: cmd_o.op = OP_EXEC;
      S_RESP: cmd_o.resp = 1'b1;
      default: cmd_o.op = OP_NOP;
    endcase
  end

  // State and scan counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ent_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          ent_q <= '0;
          if (start_i) state_q <= (kind_i == KIND_TICK) ? S_TINC : S_EXEC;
        end
        S_TINC: state_q <= S_DUE;
        S_DUE: begin
          ent_q <= ent_q + 1'b1;
          if (last_ent) state_q <= S_SCAN;
        end
        S_SCAN: begin
          ent_q <= ent_q + 1'b1;
          if (last_ent) state_q <= stat_i.due_none ? S_IDLE : S_FIRE;
        end
        S_FIRE: state_q <= S_EMIT;
        S_EMIT: begin
          ent_q   <= '0;
          state_q <= stat_i.due_none ? S_IDLE : S_SCAN;
        end
        S_EXEC: state_q <= S_RESP;
        S_RESP: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/stb_dp.sv */
// Datapath of the software timer bank: timer state, due search, results.
// Depends on stb_pkg.
module stb_dp import stb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  input  logic [2:0]        kind_i,
  input  logic [TIDX_W-1:0] timer_index_i,
  input  logic [31:0]       period_i,
  input  logic              auto_reload_i,
  output dp_stat_t          stat_o,
  output logic              done_o,
  output logic [TIDX_W-1:0] timer_index_res_o,
  output logic              expired_o,
  output logic              status_o,
  output logic              running_o,
  output logic [30:0]       remaining_o,
  output logic [31:0]       period_now_o,
  output logic              last_o
);

  logic [31:0]           tick_q;
  logic [31:0]           exp_q  [NUM_TIMERS];
  logic [31:0]           per_q  [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] rel_q, run_q, due_q;
  logic [CNT_W-1:0]      due_cnt_q;
  logic [TIDX_W-1:0]     best_q;
  logic [31:0]           best_late_q;
  logic                  found_q;
  logic                  st_q;

  // latched command
  logic [2:0]        kind_q;
  logic [TIDX_W-1:0] idx_q;
  logic [31:0]       pin_q;
  logic              rin_q;

  logic        idx_ok;
  logic [31:0] d_ent, late_ent;

  assign idx_ok   = ({1'b0, idx_q} < (TIDX_W + 1)'(NUM_TIMERS));
  assign d_ent    = exp_q[cmd_i.ent] - tick_q;
  assign late_ent = tick_q - exp_q[cmd_i.ent];
  assign stat_o.due_none = (due_cnt_q == '0);

  // Input latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      kind_q <= kind_i;
      idx_q  <= timer_index_i;
      pin_q  <= period_i;
      rin_q  <= auto_reload_i;
    end
  end

  // Timer state, due tracking and command execution
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q      <= '0;
      exp_q       <= '{default: '0};
      per_q       <= '{default: '0};
      rel_q       <= '0;
      run_q       <= '0;
      due_q       <= '0;
      due_cnt_q   <= '0;
      best_q      <= '0;
      best_late_q <= '0;
      found_q     <= 1'b0;
      st_q        <= 1'b0;
    end else begin
      case (cmd_i.op)
        OP_TICK: begin
          tick_q    <= tick_q + 32'd1;
          due_cnt_q <= '0;
        end
        OP_DUE: begin
          due_q[cmd_i.ent] <= run_q[cmd_i.ent] && (d_ent == 32'd0 || d_ent[31]);
          if (run_q[cmd_i.ent] && (d_ent == 32'd0 || d_ent[31]))
            due_cnt_q <= due_cnt_q + 1'b1;
        end
        OP_SCAN: begin
          // lower index wins ties: only a strictly later timer replaces
          if (cmd_i.ent == '0) found_q <= due_q[cmd_i.ent];
          if (due_q[cmd_i.ent] &&
              (cmd_i.ent == '0 || !found_q || late_ent > best_late_q)) begin
            best_q      <= cmd_i.ent;
            best_late_q <= late_ent;
            found_q     <= 1'b1;
          end
        end
        OP_FIRE: begin
          due_q[best_q] <= 1'b0;
          due_cnt_q     <= due_cnt_q - 1'b1;
          if (rel_q[best_q]) exp_q[best_q] <= tick_q + per_q[best_q];
          else               run_q[best_q] <= 1'b0;
        end
        OP_EXEC: begin
          st_q <= 1'b0;
          if (idx_ok) begin
            case (kind_q)
              KIND_SETUP: begin
                if (pin_q == 32'd0) st_q <= 1'b1;
                else begin
                  per_q[idx_q] <= pin_q;
                  rel_q[idx_q] <= rin_q;
                  exp_q[idx_q] <= '0;
                  run_q[idx_q] <= 1'b0;
                end
              end
              KIND_START: begin
                if (per_q[idx_q] == 32'd0) st_q <= 1'b1;
                else begin
                  exp_q[idx_q] <= tick_q + per_q[idx_q];
                  run_q[idx_q] <= 1'b1;
                end
              end
              KIND_STOP: run_q[idx_q] <= 1'b0;
              KIND_CHANGE: begin
                if (pin_q == 32'd0) st_q <= 1'b1;
                else begin
                  per_q[idx_q] <= pin_q;
                  if (run_q[idx_q]) exp_q[idx_q] <= tick_q + pin_q;
                end
              end
              KIND_QUERY: st_q <= 1'b0;
              default: st_q <= 1'b1;
            endcase
          end else begin
            st_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Result registers, one-cycle strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= (cmd_i.op == OP_EMIT) || cmd_i.resp;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_EMIT) begin
      timer_index_res_o <= best_q;
      expired_o         <= 1'b1;
      status_o          <= 1'b0;
      running_o         <= run_q[best_q];
      remaining_o       <= ticks_left(run_q[best_q], exp_q[best_q], tick_q);
      period_now_o      <= per_q[best_q];
      last_o            <= (due_cnt_q == '0);
    end else if (cmd_i.resp) begin
      timer_index_res_o <= idx_q;
      expired_o         <= 1'b0;
      status_o          <= st_q;
      running_o         <= idx_ok && run_q[idx_q];
      remaining_o       <= idx_ok ? ticks_left(run_q[idx_q], exp_q[idx_q], tick_q) : '0;
      period_now_o      <= idx_ok ? per_q[idx_q] : '0;
      last_o            <= 1'b1;
    end
  end

endmodule

/* hw/rtl/software_timer_bank.sv */
// Top level of the software timer bank: controller plus datapath.
// Depends on stb_pkg, stb_ctrl, stb_dp.
//
//  channel   | handshake            | payload
//  ----------+----------------------+----------------------------------------------
//  command   | start / busy         | kind_i, timer_index_i, period_i, auto_reload_i
//  result    | done_o (1-cycle)     | timer_index_res_o, expired_o, status_o,
//            |                      | running_o, remaining_o, period_now_o, last_o
//
// A command keeps busy high through its execute and respond states; its result
// strobe is registered from the respond state. A tick steps the counter, does a
// due pass over all timers, then per expiry a search over the single timer-state
// read port, a fire and an emit (an empty search if none is due). Reset clears all
// timers and the counter. Results cannot be stalled; busy is low only when idle.
module software_timer_bank import stb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        kind_i,
  input  logic [TIDX_W-1:0] timer_index_i,
  input  logic [31:0]       period_i,
  input  logic              auto_reload_i,
  output logic              done_o,
  output logic [TIDX_W-1:0] timer_index_res_o,
  output logic              expired_o,
  output logic              status_o,
  output logic              running_o,
  output logic [30:0]       remaining_o,
  output logic [31:0]       period_now_o,
  output logic              last_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  stb_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .kind_i (kind_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  stb_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .kind_i           (kind_i),
    .timer_index_i    (timer_index_i),
    .period_i         (period_i),
    .auto_reload_i    (auto_reload_i),
    .stat_o           (stat),
    .done_o           (done_o),
    .timer_index_res_o(timer_index_res_o),
    .expired_o        (expired_o),
    .status_o         (status_o),
    .running_o        (running_o),
    .remaining_o      (remaining_o),
    .period_now_o     (period_now_o),
    .last_o           (last_o)
  );

  // No result in the cycle right after a transaction is accepted
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !done_o) else $error("result too early");

  // Command results are single and final
  a_cmd_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !expired_o) |-> last_o) else $error("command result not last");

  // Expiry results never carry an error
  a_exp_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && expired_o) |-> !status_o) else $error("expiry with error");

endmodule

/* bench/stb_checker.sv */
// Result checker for the software timer bank: predicts every result from the
// accepted command transactions and compares them with the result strobes.
// Depends on stb_pkg.
`timescale 1ns / 1ps

module stb_checker import stb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  logic [2:0]        kind_i,
  input  logic [TIDX_W-1:0] timer_index_i,
  input  logic [31:0]       period_i,
  input  logic              auto_reload_i,
  input  logic              done_i,
  input  logic [TIDX_W-1:0] timer_index_res_i,
  input  logic              expired_i,
  input  logic              status_i,
  input  logic              running_i,
  input  logic [30:0]       remaining_i,
  input  logic [31:0]       period_now_i,
  input  logic              last_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                expiries_o,
  output int                results_o
);

  typedef struct packed {
    logic [TIDX_W-1:0] idx;
    logic              expired;
    logic              status;
    logic              running;
    logic [30:0]       remaining;
    logic [31:0]       period;
    logic              last;
  } timer_result_t;

  // Model copy of the timer bank state
  logic [31:0] now_q;
  logic [31:0] exp_q [NUM_TIMERS];
  logic [31:0] per_q [NUM_TIMERS];
  logic        rel_q [NUM_TIMERS];
  logic        run_q [NUM_TIMERS];

  timer_result_t result_fifo[$];

  function automatic logic [30:0] left_ticks(int i);
    logic [31:0] d;
    d = exp_q[i] - now_q;
    if (!run_q[i] || d == 32'd0 || d[31]) return 31'd0;
    return d[30:0];
  endfunction

  function automatic timer_result_t timer_status(int i, logic st);
    timer_result_t r;
    r.idx = i[TIDX_W-1:0];
    r.expired = 1'b0;
    r.status = st;
    r.running = run_q[i];
    r.remaining = left_ticks(i);
    r.period = per_q[i];
    r.last = 1'b1;
    return r;
  endfunction

  // Advance the counter and queue the expiries, most overdue first
  task automatic predict_tick();
    logic        due [NUM_TIMERS];
    logic [31:0] late [NUM_TIMERS];
    logic [31:0] d;
    int total, best;
    timer_result_t r;
    total = 0;
    now_q = now_q + 32'd1;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      d = exp_q[i] - now_q;
      due[i] = run_q[i] && (d == 32'd0 || d[31]);
      late[i] = now_q - exp_q[i];
      if (due[i]) total++;
    end
    if (total > 16) total = 16;
    for (int n = 0; n < total; n++) begin
      best = -1;
      for (int i = 0; i < NUM_TIMERS; i++)
        if (due[i] && (best < 0 || late[i] > late[best])) best = i;
      due[best] = 1'b0;
      if (rel_q[best]) exp_q[best] = now_q + per_q[best];
      else run_q[best] = 1'b0;
      r = timer_status(best, 1'b0);
      r.expired = 1'b1;
      r.last = (n + 1 == total);
      result_fifo.push_back(r);
    end
  endtask

  task automatic predict_command(logic [2:0] kind, int i, logic [31:0] per, logic rel);
    logic st;
    st = 1'b0;
    case (kind)
      KIND_SETUP: begin
        if (per == 32'd0) st = 1'b1;
        else begin
          per_q[i] = per;
          rel_q[i] = rel;
          exp_q[i] = 32'd0;
          run_q[i] = 1'b0;
        end
      end
      KIND_START: begin
        if (per_q[i] == 32'd0) st = 1'b1;
        else begin
          exp_q[i] = now_q + per_q[i];
          run_q[i] = 1'b1;
        end
      end
      KIND_STOP:  run_q[i] = 1'b0;
      KIND_CHANGE: begin
        if (per == 32'd0) st = 1'b1;
        else begin
          per_q[i] = per;
          if (run_q[i]) exp_q[i] = now_q + per;
        end
      end
      KIND_QUERY: ;
      default: st = 1'b1;
    endcase
    result_fifo.push_back(timer_status(i, st));
  endtask

  timer_result_t seen, want;

  // Compare results first, then take in a newly accepted transaction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q = '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        exp_q[i] = '0;
        per_q[i] = '0;
        rel_q[i] = 1'b0;
        run_q[i] = 1'b0;
      end
      result_fifo.delete();
      fail_count_o = 0;
      expiries_o = 0;
      results_o = 0;
    end else begin
      if (done_i) begin
        seen = '{timer_index_res_i, expired_i, status_i, running_i, remaining_i,
                 period_now_i, last_i};
        results_o++;
        if (expired_i) expiries_o++;
        if (result_fifo.size() == 0) begin
          $display("%0t: unexpected result, actual %p", $time, seen);
          fail_count_o++;
        end else begin
          want = result_fifo.pop_front();
          if (seen.idx != want.idx || seen.expired != want.expired ||
              seen.status != want.status || seen.running != want.running ||
              seen.remaining != want.remaining || seen.period != want.period ||
              seen.last != want.last) begin
            $display("%0t: result mismatch, expected %p, actual %p", $time, want, seen);
            fail_count_o++;
          end
        end
      end
      if (start_i && !busy_i) begin
        if (kind_i == KIND_TICK) predict_tick();
        else predict_command(kind_i, int'(timer_index_i), period_i, auto_reload_i);
      end
    end
    pending_o = result_fifo.size();
  end

endmodule

/* bench/software_timer_bank_test.sv */
// Testbench top for the software timer bank: drives command transactions in
// bursts and gives the verdict. Depends on stb_pkg, stb_checker, software_timer_bank.
`timescale 1ns / 1ps

module software_timer_bank_test;
  import stb_pkg::*;

  localparam logic [2:0] KIND_UNUSED_A = 3'd6;
  localparam logic [2:0] KIND_UNUSED_B = 3'd7;
  localparam int RANDOM_ITEMS = 240;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [2:0]        kind_i = KIND_TICK;
  logic [TIDX_W-1:0] timer_index_i = '0;
  logic [31:0]       period_i = '0;
  logic              auto_reload_i = 1'b0;
  logic              done_o, expired_o, status_o, running_o, last_o;
  logic [TIDX_W-1:0] timer_index_res_o;
  logic [30:0]       remaining_o;
  logic [31:0]       period_now_o;
  int                fail_count, pending, expiries, results;
  int                sent;

  always #6 clk_i = ~clk_i;

  software_timer_bank u_dut (
    .clk_i, .rst_ni, .start, .busy, .kind_i, .timer_index_i, .period_i,
    .auto_reload_i, .done_o, .timer_index_res_o, .expired_o, .status_o,
    .running_o, .remaining_o, .period_now_o, .last_o
  );

  stb_checker u_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .kind_i, .timer_index_i,
    .period_i, .auto_reload_i, .done_i(done_o), .timer_index_res_i(timer_index_res_o),
    .expired_i(expired_o), .status_i(status_o), .running_i(running_o),
    .remaining_i(remaining_o), .period_now_i(period_now_o), .last_i(last_o),
    .fail_count_o(fail_count), .pending_o(pending), .expiries_o(expiries),
    .results_o(results)
  );

  // One command transaction; start is held until accepted
  task automatic send_cmd(logic [2:0] kind, int idx, logic [31:0] per, logic rel);
    do @(negedge clk_i); while (busy);
    kind_i <= kind;
    timer_index_i <= idx[TIDX_W-1:0];
    period_i <= per;
    auto_reload_i <= rel;
    start <= 1'b1;
    @(negedge clk_i);
    start <= 1'b0;
    sent++;
  endtask

  function automatic logic [31:0] pick_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return 32'd0;
    if (r < 20) return $urandom();
    if (r < 24) return 32'h8000_0000 | $urandom_range(0, 3);
    return $urandom_range(1, 8);
  endfunction

  function automatic logic [2:0] pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return KIND_TICK;
    if (r < 52) return KIND_SETUP;
    if (r < 68) return KIND_START;
    if (r < 76) return KIND_STOP;
    if (r < 84) return KIND_CHANGE;
    if (r < 96) return KIND_QUERY;
    return (r < 98) ? KIND_UNUSED_A : KIND_UNUSED_B;
  endfunction

  initial begin
    int burst, gap;
    sent = 0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Directed: never set up, zero periods, unknown kinds, extreme periods
    send_cmd(KIND_START, 3, 32'd0, 1'b0);
    send_cmd(KIND_SETUP, 0, 32'd0, 1'b1);
    send_cmd(KIND_CHANGE, 0, 32'd0, 1'b0);
    send_cmd(KIND_UNUSED_A, 15, 32'hFFFF_FFFF, 1'b1);
    send_cmd(KIND_UNUSED_B, 0, 32'd0, 1'b0);
    send_cmd(KIND_TICK, 0, 32'd0, 1'b0);
    send_cmd(KIND_SETUP, 15, 32'hFFFF_FFFF, 1'b1);
    send_cmd(KIND_START, 15, 32'd0, 1'b0);
    send_cmd(KIND_QUERY, 15, 32'd0, 1'b0);
    send_cmd(KIND_SETUP, 14, 32'h8000_0000, 1'b0);
    send_cmd(KIND_START, 14, 32'd0, 1'b0);
    send_cmd(KIND_TICK, 0, 32'd0, 1'b0);
    send_cmd(KIND_SETUP, 15, 32'd1, 1'b0);
    send_cmd(KIND_STOP, 15, 32'd0, 1'b0);
    // All sixteen timers due on the same tick
    for (int i = 0; i < NUM_TIMERS; i++) send_cmd(KIND_SETUP, i, 32'd1, i[0]);
    for (int i = NUM_TIMERS - 1; i >= 0; i--) send_cmd(KIND_START, i, 32'd0, 1'b0);
    send_cmd(KIND_TICK, 0, 32'd0, 1'b0);
    send_cmd(KIND_CHANGE, 1, 32'd3, 1'b0);
    send_cmd(KIND_TICK, 0, 32'd0, 1'b0);
    send_cmd(KIND_TICK, 0, 32'd0, 1'b0);

    // Random bursts with gaps between them
    while (sent < RANDOM_ITEMS + 20) begin
      burst = $urandom_range(1, 10);
      for (int b = 0; b < burst; b++)
        send_cmd(pick_kind(), $urandom_range(0, NUM_TIMERS - 1), pick_period(),
                 $urandom_range(0, 1));
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) @(negedge clk_i);
      // Hold off until the bank has drained after bursts that end with 151 to 161 sent
      if (sent > 150 && sent < 162) begin
        do @(negedge clk_i); while (pending != 0 || busy);
      end
    end

    do @(negedge clk_i); while (pending != 0 || busy);
    repeat (60) @(negedge clk_i);
    $display("Sent %0d command transactions, checked %0d results, %0d of them expiries.",
             sent, results, expiries);
    if (fail_count == 0 && pending == 0)
      $display("software_timer_bank_test OK");
    else
      $display("software_timer_bank_test NOT OK");
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("Timed out waiting for the bank.");
    $display("software_timer_bank_test NOT OK");
    $finish;
  end

endmodule
